[design/alpf_pkg.sv]
// ----------------------------------------------------------------------------
// alpf_pkg: shared types, codes and microcode for the limited position follower
// Holds the control word layout, the sequencer condition codes and the
// read-only microprogram that steps the datapath through one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

package alpf_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int DT_W    = 16;
    localparam int CFG_W   = 31;
    localparam int DIV_W   = 48;
    localparam int CNT_W   = 6;
    localparam int PC_W    = 4;

    // Configuration register indexes
    localparam logic CFG_MAX_SPEED = 1'b0;
    localparam logic CFG_MAX_ACCEL = 1'b1;

    typedef logic [PC_W-1:0] t_pc;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_LOAD,    // take the input transaction
        OP_ERR,     // position error, divider setup, acceleration limit
        OP_DIV,     // one restoring division step
        OP_DES,     // clamp quotient to the speed limit
        OP_DV,      // velocity change request
        OP_VEL,     // clamp change to the acceleration limit, update velocity
        OP_MUL,     // velocity times time step
        OP_POS,     // integrate position with saturation
        OP_OUT      // load the result register
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_DT_ZERO,
        COND_CNT_NZ,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  last;
    } t_ctrl;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic dt_zero;
        logic cnt_nz;
        logic out_busy;
    } t_flags;

    // Step addresses
    localparam t_pc STEP_LOAD = 4'd0;
    localparam t_pc STEP_ERR  = 4'd1;
    localparam t_pc STEP_DIV  = 4'd2;
    localparam t_pc STEP_DES  = 4'd3;
    localparam t_pc STEP_DV   = 4'd4;
    localparam t_pc STEP_VEL  = 4'd5;
    localparam t_pc STEP_MUL  = 4'd6;
    localparam t_pc STEP_POS  = 4'd7;
    localparam t_pc STEP_OUT  = 4'd8;

    // Microprogram: a jump is taken when its condition holds, else the last word returns to load and others advance
    function automatic t_ctrl ucode_rom(t_pc pc);
        t_ctrl w;
        w = '{op: OP_LOAD, cond: COND_NO_INPUT, target: STEP_LOAD, last: 1'b0};
        case (pc)
            STEP_LOAD: w = '{op: OP_LOAD, cond: COND_NO_INPUT, target: STEP_LOAD, last: 1'b0};
            STEP_ERR:  w = '{op: OP_ERR,  cond: COND_DT_ZERO,  target: STEP_OUT,  last: 1'b0};
            STEP_DIV:  w = '{op: OP_DIV,  cond: COND_CNT_NZ,   target: STEP_DIV,  last: 1'b0};
            STEP_DES:  w = '{op: OP_DES,  cond: COND_NONE,     target: STEP_LOAD, last: 1'b0};
            STEP_DV:   w = '{op: OP_DV,   cond: COND_NONE,     target: STEP_LOAD, last: 1'b0};
            STEP_VEL:  w = '{op: OP_VEL,  cond: COND_NONE,     target: STEP_LOAD, last: 1'b0};
            STEP_MUL:  w = '{op: OP_MUL,  cond: COND_NONE,     target: STEP_LOAD, last: 1'b0};
            STEP_POS:  w = '{op: OP_POS,  cond: COND_NONE,     target: STEP_LOAD, last: 1'b0};
            STEP_OUT:  w = '{op: OP_OUT,  cond: COND_OUT_BUSY, target: STEP_OUT,  last: 1'b1};
            default:   w = '{op: OP_LOAD, cond: COND_NONE,     target: STEP_LOAD, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/alpf_seq.sv]
// ----------------------------------------------------------------------------
// alpf_seq: microcode sequencer
// Holds the step counter, fetches the control word from the microprogram and
// picks the next step from the jump condition.
// ----------------------------------------------------------------------------
`default_nettype none

module alpf_seq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  alpf_pkg::t_flags i_flags,
    output alpf_pkg::t_ctrl  o_ctrl
);
    import alpf_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl ctrl;
    logic  jump;

    // Fetch the current control word
    assign ctrl   = ucode_rom(r_pc);
    assign o_ctrl = ctrl;

    // Evaluate the jump condition and pick the next step
    always_comb begin
        case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_INPUT: jump = !i_flags.in_valid;
            COND_DT_ZERO:  jump = i_flags.dt_zero;
            COND_CNT_NZ:   jump = i_flags.cnt_nz;
            COND_OUT_BUSY: jump = i_flags.out_busy;
            default:       jump = 1'b0;
        endcase
        if (jump) begin
            n_pc = ctrl.target;
        end else if (ctrl.last) begin
            n_pc = STEP_LOAD;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

[design/accel_limited_position_follower_core.sv]
// ----------------------------------------------------------------------------
// accel_limited_position_follower_core: velocity and acceleration limited
// setpoint follower in Q16.16 fixed point, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. A transaction with a nonzero time step runs from
// acceptance to the result register through these steps: accept, form the
// error, the bit-serial restoring divider that turns error over time step
// into a velocity, then five steps (speed clamp, velocity change,
// acceleration clamp, velocity times time step, position update) and a final
// step that loads the result once the output is free. A zero time step skips
// the work and returns the held state. The next transaction is taken in the
// cycle after the result is loaded, while that result may still wait behind
// a stalled output. Configuration writes take effect at once and must be made
// while no transaction is in flight.
`default_nettype none

module accel_limited_position_follower_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input channel
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  signed [alpf_pkg::POS_W-1:0]    i_target_position,
    input  wire         [alpf_pkg::DT_W-1:0]     i_time_step,
    // output channel
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [alpf_pkg::POS_W-1:0]    o_position,
    output logic signed [alpf_pkg::POS_W-1:0]    o_velocity,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire                                  i_cfg_index,
    input  wire         [alpf_pkg::CFG_W-1:0]    i_cfg_data
);
    import alpf_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;

    // Registers
    logic        [CFG_W-1:0] r_max_speed;
    logic        [CFG_W-1:0] r_max_accel;
    logic signed [POS_W-1:0] r_tgt,  n_tgt;
    logic        [DT_W-1:0]  r_dt,   n_dt;
    logic                    r_neg,  n_neg;
    logic        [DIV_W-1:0] r_dq,   n_dq;
    logic        [DT_W-1:0]  r_rem,  n_rem;
    logic        [CNT_W-1:0] r_cnt,  n_cnt;
    logic        [CFG_W-1:0] r_lim,  n_lim;
    logic signed [POS_W-1:0] r_des,  n_des;
    logic signed [POS_W:0]   r_dv,   n_dv;
    logic signed [POS_W+DT_W:0] r_prod, n_prod;
    logic signed [POS_W-1:0] r_vel,  n_vel;
    logic signed [POS_W-1:0] r_pos,  n_pos;
    logic                    r_out_valid, n_out_valid;
    logic signed [POS_W-1:0] r_out_pos,   n_out_pos;
    logic signed [POS_W-1:0] r_out_vel,   n_out_vel;

    // Combinational datapath terms
    logic signed [POS_W:0]         err;
    logic        [POS_W:0]         err_abs;
    logic        [CFG_W+DT_W-1:0]  accel_prod;
    logic        [DT_W:0]          rem_sh;
    logic                          q_bit;
    logic        [DT_W:0]          rem_diff;
    logic        [CFG_W-1:0]       des_mag;
    logic        [POS_W-1:0]       des_mag32;
    logic signed [POS_W:0]         lim33;
    logic signed [POS_W:0]         dv_clamped;
    logic signed [POS_W:0]         vel_sum;
    logic signed [POS_W:0]         pos_step;
    logic signed [POS_W+1:0]       pos_sum;
    logic signed [DT_W:0]          dt_s;
    logic                          out_busy;

    // Sequencer
    alpf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign out_busy       = r_out_valid && i_stall;
    assign flags.in_valid = i_valid;
    assign flags.dt_zero  = (r_dt == '0);
    assign flags.cnt_nz   = (r_cnt != '0);
    assign flags.out_busy = out_busy;

    assign o_stall    = (ctrl.op != OP_LOAD);
    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_velocity = r_out_vel;

    // Shared arithmetic terms
    always_comb begin
        err        = {r_tgt[POS_W-1], r_tgt} - {r_pos[POS_W-1], r_pos};
        err_abs    = err[POS_W] ? ((POS_W+1)'(0) - err) : err;
        accel_prod = (CFG_W+DT_W)'(r_max_accel) * (CFG_W+DT_W)'(r_dt);
        rem_sh     = {r_rem, r_dq[DIV_W-1]};
        rem_diff   = rem_sh - {1'b0, r_dt};
        q_bit      = (rem_sh >= {1'b0, r_dt});
        des_mag    = (r_dq > DIV_W'(r_max_speed)) ? r_max_speed : r_dq[CFG_W-1:0];
        des_mag32  = {1'b0, des_mag};
        lim33      = {2'b00, r_lim};
        if (r_dv > lim33) begin
            dv_clamped = lim33;
        end else if (r_dv < -lim33) begin
            dv_clamped = -lim33;
        end else begin
            dv_clamped = r_dv;
        end
        vel_sum  = {r_vel[POS_W-1], r_vel} + dv_clamped;
        dt_s     = {1'b0, r_dt};
        pos_step = r_prod[POS_W+DT_W:DT_W];
        pos_sum  = {{2{r_pos[POS_W-1]}}, r_pos} + {pos_step[POS_W], pos_step};
    end

    // Execute the current control word
    always_comb begin
        n_tgt       = r_tgt;
        n_dt        = r_dt;
        n_neg       = r_neg;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_lim       = r_lim;
        n_des       = r_des;
        n_dv        = r_dv;
        n_prod      = r_prod;
        n_vel       = r_vel;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_stall;
        n_out_pos   = r_out_pos;
        n_out_vel   = r_out_vel;
        case (ctrl.op)
            OP_LOAD: begin
                if (i_valid) begin
                    n_tgt = i_target_position;
                    n_dt  = i_time_step;
                end
            end
            OP_ERR: begin
                n_neg = err[POS_W];
                n_dq  = {err_abs[POS_W-1:0], {DT_W{1'b0}}};
                n_rem = '0;
                n_cnt = CNT_W'(DIV_W - 1);
                n_lim = accel_prod[CFG_W+DT_W-1:DT_W];
            end
            OP_DIV: begin
                n_dq  = {r_dq[DIV_W-2:0], q_bit};
                n_rem = q_bit ? rem_diff[DT_W-1:0] : rem_sh[DT_W-1:0];
                n_cnt = r_cnt - CNT_W'(1);
            end
            OP_DES: begin
                n_des = r_neg ? (POS_W'(0) - des_mag32) : des_mag32;
            end
            OP_DV: begin
                n_dv = {r_des[POS_W-1], r_des} - {r_vel[POS_W-1], r_vel};
            end
            OP_VEL: begin
                n_vel = vel_sum[POS_W-1:0];
            end
            OP_MUL: begin
                n_prod = (POS_W+DT_W+1)'(r_vel) * (POS_W+DT_W+1)'(dt_s);
            end
            OP_POS: begin
                if (pos_sum[POS_W+1:POS_W-1] == 3'b000 ||
                    pos_sum[POS_W+1:POS_W-1] == 3'b111) begin
                    n_pos = pos_sum[POS_W-1:0];
                end else if (pos_sum[POS_W+1]) begin
                    n_pos = {1'b1, {(POS_W-1){1'b0}}};
                end else begin
                    n_pos = {1'b0, {(POS_W-1){1'b1}}};
                end
            end
            OP_OUT: begin
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_pos;
                    n_out_vel   = r_vel;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= CFG_W'(65536);
            r_max_accel <= CFG_W'(65536);
            r_vel       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_dt        <= '0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == CFG_MAX_SPEED) begin
                r_max_speed <= i_cfg_data;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_MAX_ACCEL) begin
                r_max_accel <= i_cfg_data;
            end
            r_vel       <= n_vel;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_dt        <= n_dt;
        end
    end

    // Advance payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_tgt     <= n_tgt;
        r_neg     <= n_neg;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_lim     <= n_lim;
        r_des     <= n_des;
        r_dv      <= n_dv;
        r_prod    <= n_prod;
        r_out_pos <= n_out_pos;
        r_out_vel <= n_out_vel;
    end

    // Checks
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_DIV && r_cnt != '0) |=> (ctrl.op == OP_DIV))
        else $error("divider left before its last step");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_DES) |-> (r_rem < r_dt))
        else $error("division remainder not below time step");

    a_vel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op != OP_VEL) |=> $stable(r_vel))
        else $error("velocity changed outside its update step");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (ctrl.op == OP_ERR))
        else $error("accepted transaction did not start the error step");

endmodule

`default_nettype wire
